/* sv/dssc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssc_pkg
// Shared types, constants and fixed-point helpers of the dual servo slew
// controller.
// ----------------------------------------------------------------------------
package dssc_pkg;

    localparam int ANGLE_W = 15;
    localparam int PULSE_W = 12;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 15'd9000;
    localparam logic [ANGLE_W-1:0] NOD_DIST     = 15'd200;
    localparam logic [ANGLE_W-1:0] STEP_DIST    = 15'd50;
    localparam logic [6:0]         NOD_CHANCE   = 7'd10;
    localparam logic [7:0]         NOD_BASE     = 8'd85;
    localparam logic [7:0]         M0_BASE      = 8'd30;
    localparam logic [8:0]         A0_MAX       = 9'd180;
    localparam logic [8:0]         A1_MIN       = 9'd80;
    localparam logic [8:0]         A1_MAX       = 9'd125;
    localparam logic [PULSE_W-1:0] PULSE_BASE   = 12'd500;

    typedef struct packed {
        logic               upd_a;
        logic               upd_b;
        logic [ANGLE_W-1:0] cur_a;
        logic [ANGLE_W-1:0] cur_b;
    } step_res_t;

    // Whole degrees from hundredths, exact for every 15-bit input.
    function automatic logic [8:0] div100(input logic [ANGLE_W-1:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'd20972;
        return p[29:21];
    endfunction

    // Pulse width 500 + floor(m * 2000 / 180), exact for m up to 255.
    function automatic logic [PULSE_W-1:0] pulse_of_m(input logic [7:0] m);
        logic [14:0] z;
        logic [28:0] p;
        z = 15'(m) * 15'd100;
        p = 29'(z) * 29'd14564;
        return PULSE_BASE + p[28:17];
    endfunction

endpackage

/* sv/dual_servo_slew_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result path: a tick word passes the input register, the step register and
// the result register in turn; set-target words give none.
// Throughput: one word per cycle, limited only by the result handshake.
// Reset: both channels' current and target angles return to 90.00 degrees.
// ----------------------------------------------------------------------------
// dual_servo_slew_controller
// Two-channel servo slew controller with a three-register pipeline.
// ----------------------------------------------------------------------------
module dual_servo_slew_controller
    import dssc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [1:0]         s_index,
    input  logic [7:0]         s_angle,
    input  logic [6:0]         s_nod_chance,
    input  logic [5:0]         s_nod_offset,
    input  logic [2:0]         s_speed_draw_a,
    input  logic [2:0]         s_speed_draw_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PULSE_W-1:0] m_pulse_a,
    output logic [PULSE_W-1:0] m_pulse_b,
    output logic               m_update_a,
    output logic               m_update_b
);

    logic        in_valid_reg, mid_valid_reg, out_valid_reg;
    logic        action_reg;
    logic [1:0]  index_reg;
    logic [7:0]  angle_reg;
    logic [6:0]  chance_reg;
    logic [5:0]  offset_reg;
    logic [2:0]  da_reg, db_reg;
    step_res_t   step_res, mid_reg;
    logic [PULSE_W-1:0] pulse_a, pulse_b;
    logic        out_free, mid_free, in_adv, tick_adv;

    assign out_free = !out_valid_reg || m_ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_adv   = in_valid_reg && ((action_reg == ACT_SET) || mid_free);
    assign tick_adv = in_adv && (action_reg == ACT_TICK);
    assign s_ready  = !in_valid_reg || in_adv;

    dssc_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (in_adv),
        .action       (action_reg),
        .index        (index_reg),
        .angle        (angle_reg),
        .nod_chance   (chance_reg),
        .nod_offset   (offset_reg),
        .speed_draw_a (da_reg),
        .speed_draw_b (db_reg),
        .res          (step_res)
    );

    dssc_pulse u_pulse (
        .res     (mid_reg),
        .pulse_a (pulse_a),
        .pulse_b (pulse_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_free) begin
                mid_valid_reg <= tick_adv;
            end
            if (out_free) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            action_reg <= s_action;
            index_reg  <= s_index;
            angle_reg  <= s_angle;
            chance_reg <= s_nod_chance;
            offset_reg <= s_nod_offset;
            da_reg     <= s_speed_draw_a;
            db_reg     <= s_speed_draw_b;
        end
        if (mid_free && tick_adv) begin
            mid_reg <= step_res;
        end
        if (out_free && mid_valid_reg) begin
            m_pulse_a  <= pulse_a;
            m_pulse_b  <= pulse_b;
            m_update_a <= mid_reg.upd_a;
            m_update_b <= mid_reg.upd_b;
        end
    end

    assign m_valid = out_valid_reg;

`ifndef SYNTH
    a_idle_pulse_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_update_a |-> m_pulse_a == '0)
        else $error("pulse_a nonzero without an update");

    a_range_pulse_b: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_update_b |-> m_pulse_b >= 12'd1388 && m_pulse_b <= 12'd1888)
        else $error("pulse_b outside its clamped range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && action_reg == ACT_TICK && mid_valid_reg)
        else $error("input stalled without a pending tick");
`endif

endmodule

/* sv/dssc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssc_step
// Angle state of both channels, target loads, the random nod of channel 1
// and the slew step toward each target.
// ----------------------------------------------------------------------------
module dssc_step
    import dssc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              action,
    input  logic [1:0]        index,
    input  logic [7:0]        angle,
    input  logic [6:0]        nod_chance,
    input  logic [5:0]        nod_offset,
    input  logic [2:0]        speed_draw_a,
    input  logic [2:0]        speed_draw_b,
    output step_res_t         res
);

    logic [ANGLE_W-1:0] cur_a_reg, cur_b_reg, tgt_a_reg, tgt_b_reg;
    logic [ANGLE_W-1:0] cur_a_next, cur_b_next, tgt_a_next, tgt_b_next;
    logic [ANGLE_W-1:0] dist_a, dist_b, tgt_b_eff, set_val;
    logic [6:0]         speed_a, speed_b;
    logic               nod, move_a, move_b;

    function automatic logic [ANGLE_W-1:0] slew(input logic [ANGLE_W-1:0] cur,
                                                input logic [ANGLE_W-1:0] tgt,
                                                input logic [6:0] spd);
        logic [ANGLE_W:0] up;
        up = {1'b0, cur} + 16'(spd);
        if (cur < tgt) begin
            return (up > {1'b0, tgt}) ? tgt : up[ANGLE_W-1:0];
        end else begin
            return ((cur - tgt) > 15'(spd)) ? (cur - 15'(spd)) : tgt;
        end
    endfunction

    always_comb begin
        set_val   = 15'(angle) * 15'd100;
        dist_a    = (cur_a_reg > tgt_a_reg) ? (cur_a_reg - tgt_a_reg)
                                            : (tgt_a_reg - cur_a_reg);
        nod       = (dist_a > NOD_DIST) && (nod_chance < NOD_CHANCE);
        tgt_b_eff = nod ? (15'(8'(nod_offset) + NOD_BASE) * 15'd100) : tgt_b_reg;
        dist_b    = (cur_b_reg > tgt_b_eff) ? (cur_b_reg - tgt_b_eff)
                                            : (tgt_b_eff - cur_b_reg);
        move_a    = dist_a > STEP_DIST;
        move_b    = dist_b > STEP_DIST;
        speed_a   = 7'd36 + 7'(speed_draw_a) * 7'd12;
        speed_b   = 7'd30 + 7'(speed_draw_b) * 7'd10;

        res.upd_a = move_a;
        res.upd_b = move_b;
        res.cur_a = move_a ? slew(cur_a_reg, tgt_a_reg, speed_a) : cur_a_reg;
        res.cur_b = move_b ? slew(cur_b_reg, tgt_b_eff, speed_b) : cur_b_reg;

        cur_a_next = cur_a_reg;
        cur_b_next = cur_b_reg;
        tgt_a_next = tgt_a_reg;
        tgt_b_next = tgt_b_reg;
        if (en) begin
            if (action == ACT_SET) begin
                if (index == 2'd0) begin
                    tgt_a_next = set_val;
                end
                if (index == 2'd1) begin
                    tgt_b_next = set_val;
                end
            end else begin
                tgt_b_next = tgt_b_eff;
                cur_a_next = res.cur_a;
                cur_b_next = res.cur_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_a_reg <= ANGLE_RESET;
            cur_b_reg <= ANGLE_RESET;
            tgt_a_reg <= ANGLE_RESET;
            tgt_b_reg <= ANGLE_RESET;
        end else begin
            cur_a_reg <= cur_a_next;
            cur_b_reg <= cur_b_next;
            tgt_a_reg <= tgt_a_next;
            tgt_b_reg <= tgt_b_next;
        end
    end

endmodule

/* sv/dssc_pulse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssc_pulse
// Maps the stepped angle of each moved channel to its PWM pulse width.
// ----------------------------------------------------------------------------
module dssc_pulse
    import dssc_pkg::*;
(
    input  step_res_t          res,
    output logic [PULSE_W-1:0] pulse_a,
    output logic [PULSE_W-1:0] pulse_b
);

    logic [8:0]  deg_a, deg_b, clip_a, clip_b;
    logic [17:0] third;
    logic [7:0]  m_a, m_b;

    always_comb begin
        deg_a  = div100(res.cur_a);
        deg_b  = div100(res.cur_b);
        clip_a = (deg_a > A0_MAX) ? A0_MAX : deg_a;
        // Two thirds of the angle by reciprocal multiply, exact below 256.
        third  = 18'({clip_a[7:0], 1'b0}) * 18'd342;
        m_a    = M0_BASE + third[17:10];
        clip_b = (deg_b < A1_MIN) ? A1_MIN : ((deg_b > A1_MAX) ? A1_MAX : deg_b);
        m_b    = clip_b[7:0];
        pulse_a = res.upd_a ? pulse_of_m(m_a) : '0;
        pulse_b = res.upd_b ? pulse_of_m(m_b) : '0;
    end

endmodule
